[sv/mwem_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwem_pkg
// Shared constants and types of the Microwire EEPROM master.
// ----------------------------------------------------------------------------
package mwem_pkg;

  localparam int ADDR_BITS  = 8;
  localparam int DATA_BITS  = 16;
  localparam int COUNT_BITS = ADDR_BITS + 1;
  localparam int HEAD_BITS  = 3 + ADDR_BITS;
  localparam int FRAME_BITS = HEAD_BITS + DATA_BITS;
  localparam int BC_W       = $clog2(FRAME_BITS + 1);

  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_WEN   = 3'd3;
  localparam logic [2:0] ACT_WDS   = 3'd4;
  localparam logic [2:0] ACT_WRAL  = 3'd5;

  localparam logic [1:0] OP_CTRL  = 2'b00;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] OP_READ  = 2'b10;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_DUMMY = 4'd1,
    PH_FRAME = 4'd2,
    PH_READ  = 4'd3,
    PH_GAP   = 4'd4,
    PH_POLL  = 4'd5
  } phase_t;

  typedef struct packed {
    logic                 cs;
    logic                 sk;
    logic                 di;
    logic [DATA_BITS-1:0] word;
    logic                 valid;
    logic                 last;
    logic                 busy;
  } result_t;

endpackage

[sv/microwire_eeprom_master_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// microwire_eeprom_master_top
// Microwire serial EEPROM master, one half period of SK per input word.
// ----------------------------------------------------------------------------
// Each accepted input word is one half-clock tick and yields one result word
// in the next cycle from the output register; a new tick is taken every cycle,
// also while a result waits, as long as the output register is empty or
// being drained in that cycle. The sequencer state advances once per tick.
module microwire_eeprom_master_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    action,
  input  logic [mwem_pkg::ADDR_BITS-1:0]  address,
  input  logic [mwem_pkg::DATA_BITS-1:0]  write_data,
  input  logic [mwem_pkg::COUNT_BITS-1:0] word_count,
  input  logic                          serial_data_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          chip_select,
  output logic                          serial_clock,
  output logic                          serial_data_out,
  output logic [mwem_pkg::DATA_BITS-1:0]  read_word,
  output logic                          word_valid,
  output logic                          last_word,
  output logic                          busy_res
);
  import mwem_pkg::*;

  logic    step;
  result_t result;
  result_t result_q;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  mwem_fsm u_fsm (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .action         (action),
    .address        (address),
    .write_data     (write_data),
    .word_count     (word_count),
    .serial_data_in (serial_data_in),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign chip_select     = result_q.cs;
  assign serial_clock    = result_q.sk;
  assign serial_data_out = result_q.di;
  assign read_word       = result_q.word;
  assign word_valid      = result_q.valid;
  assign last_word       = result_q.last;
  assign busy_res        = result_q.busy;

endmodule

[sv/mwem_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwem_fsm
// Serial sequencer: advances one half-clock tick per accepted word and
// forms the pin levels and read results of that tick.
// ----------------------------------------------------------------------------
module mwem_fsm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [2:0]                    action,
  input  logic [mwem_pkg::ADDR_BITS-1:0]  address,
  input  logic [mwem_pkg::DATA_BITS-1:0]  write_data,
  input  logic [mwem_pkg::COUNT_BITS-1:0] word_count,
  input  logic                          serial_data_in,
  output mwem_pkg::result_t             result
);
  import mwem_pkg::*;

  phase_t                phase, phase_next;
  logic [BC_W-1:0]       bit_counter, bit_counter_next;
  logic [FRAME_BITS-1:0] out_shift, out_shift_next;
  logic [DATA_BITS-1:0]  in_shift, in_shift_next;
  logic [COUNT_BITS-1:0] words_left, words_left_next;
  logic [2:0]            command, command_next;
  logic                  cs, cs_next, sk, sk_next, di, di_next;

  logic [1:0]            ld_op;
  logic [ADDR_BITS-1:0]  ld_addr;
  logic                  ld_data;
  logic [FRAME_BITS-1:0] ld_frame;
  logic [BC_W-1:0]       ld_len;
  logic [BC_W-1:0]       bc_dec;
  logic [DATA_BITS-1:0]  in_shifted;
  logic [COUNT_BITS-1:0] wl_dec;
  logic                  valid, last;
  logic [DATA_BITS-1:0]  word;

  function automatic logic frame_bit(input logic [FRAME_BITS-1:0] sh,
                                     input logic [BC_W-1:0] idx);
    logic b;
    b = 1'b0;
    if (idx != '0 && idx <= BC_W'(FRAME_BITS)) begin
      b = sh[idx - 1'b1];
    end
    return b;
  endfunction

  always_comb begin
    ld_op   = OP_CTRL;
    ld_addr = address;
    ld_data = 1'b0;
    unique case (action)
      ACT_READ: begin
        ld_op = OP_READ;
      end
      ACT_WRITE: begin
        ld_op   = OP_WRITE;
        ld_data = 1'b1;
      end
      ACT_WEN: begin
        ld_addr = '1;
      end
      ACT_WDS: begin
        ld_addr = '0;
      end
      default: begin
        ld_addr = {1'b0, {(ADDR_BITS-1){1'b1}}};
        ld_data = 1'b1;
      end
    endcase
    if (ld_data) begin
      ld_frame = {1'b1, ld_op, ld_addr, write_data};
      ld_len   = BC_W'(FRAME_BITS);
    end else begin
      ld_frame = {{DATA_BITS{1'b0}}, 1'b1, ld_op, ld_addr};
      ld_len   = BC_W'(HEAD_BITS);
    end
  end

  assign bc_dec     = (bit_counter != '0) ? bit_counter - 1'b1 : '0;
  assign in_shifted = {in_shift[DATA_BITS-2:0], serial_data_in};
  assign wl_dec     = (words_left != '0) ? words_left - 1'b1 : '0;

  always_comb begin
    phase_next       = phase;
    bit_counter_next = bit_counter;
    out_shift_next   = out_shift;
    in_shift_next    = in_shift;
    words_left_next  = words_left;
    command_next     = command;
    cs_next          = cs;
    sk_next          = sk;
    di_next          = di;
    unique case (phase)
      PH_IDLE: begin
        cs_next = 1'b0;
        sk_next = 1'b0;
        di_next = 1'b0;
        if (action >= ACT_READ && action <= ACT_WRAL) begin
          command_next     = action;
          out_shift_next   = ld_frame;
          bit_counter_next = ld_len;
          cs_next          = 1'b1;
          phase_next       = PH_DUMMY;
        end
      end
      PH_DUMMY: begin
        if (!sk) begin
          sk_next = 1'b1;
        end else begin
          sk_next    = 1'b0;
          di_next    = frame_bit(out_shift, bit_counter);
          phase_next = PH_FRAME;
        end
      end
      PH_FRAME: begin
        if (!sk) begin
          sk_next = 1'b1;
        end else begin
          sk_next          = 1'b0;
          bit_counter_next = bc_dec;
          if (bc_dec != '0) begin
            di_next = frame_bit(out_shift, bc_dec);
          end else begin
            di_next = 1'b0;
            if (command == ACT_READ) begin
              phase_next       = PH_READ;
              bit_counter_next = BC_W'(DATA_BITS);
              words_left_next  = (word_count == '0) ? COUNT_BITS'(1) : word_count;
              in_shift_next    = '0;
            end else if (command == ACT_WRITE || command == ACT_WRAL) begin
              cs_next    = 1'b0;
              phase_next = PH_GAP;
            end else begin
              cs_next    = 1'b0;
              phase_next = PH_IDLE;
            end
          end
        end
      end
      PH_READ: begin
        if (!sk) begin
          sk_next = 1'b1;
        end else begin
          sk_next          = 1'b0;
          in_shift_next    = in_shifted;
          bit_counter_next = bc_dec;
          if (bc_dec == '0) begin
            words_left_next = wl_dec;
            if (wl_dec == '0) begin
              cs_next    = 1'b0;
              phase_next = PH_IDLE;
            end else begin
              bit_counter_next = BC_W'(DATA_BITS);
            end
          end
        end
      end
      PH_GAP: begin
        cs_next    = 1'b1;
        sk_next    = 1'b0;
        di_next    = 1'b0;
        phase_next = PH_POLL;
      end
      PH_POLL: begin
        if (serial_data_in) begin
          cs_next    = 1'b0;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        cs_next    = 1'b0;
        sk_next    = 1'b0;
        di_next    = 1'b0;
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    valid = (phase == PH_READ) && sk && (bc_dec == '0);
    last  = valid && (wl_dec == '0);
    word  = valid ? in_shifted : '0;
  end

  assign result = '{cs:    cs_next,
                    sk:    sk_next,
                    di:    di_next,
                    word:  word,
                    valid: valid,
                    last:  last,
                    busy:  phase_next != PH_IDLE};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_counter <= '0;
      out_shift   <= '0;
      in_shift    <= '0;
      words_left  <= '0;
      command     <= ACT_TICK;
      cs          <= 1'b0;
      sk          <= 1'b0;
      di          <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      bit_counter <= bit_counter_next;
      out_shift   <= out_shift_next;
      in_shift    <= in_shift_next;
      words_left  <= words_left_next;
      command     <= command_next;
      cs          <= cs_next;
      sk          <= sk_next;
      di          <= di_next;
    end
  end

  a_idle_pins_low: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> (!cs && !sk && !di))
    else $error("pins not low in idle");

  a_cs_held: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DUMMY || phase == PH_FRAME || phase == PH_READ || phase == PH_POLL)
      |-> cs)
    else $error("chip select low during command");

  a_gap_cs_low: assert property (@(posedge clk) disable iff (rst)
    phase == PH_GAP |-> !cs)
    else $error("chip select high in gap");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_IDLE && action >= ACT_READ && action <= ACT_WRAL)
      |=> (phase == PH_DUMMY && cs))
    else $error("command not started");

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    bit_counter <= BC_W'(FRAME_BITS))
    else $error("bit counter out of range");

endmodule

[verif/mwem_checker_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwem_checker_pkg
// Tick-level pin and read-word predictor for the Microwire EEPROM master.
// Each accepted tick advances a private copy of the sequencer. The expected
// pin levels, read word and flags are queued and then compared field by field
// with the results that the block returns.
// ----------------------------------------------------------------------------
package mwem_checker_pkg;

  import mwem_pkg::*;

  class mwem_checker;

    phase_t                  state;
    int                      bits_left;
    logic [FRAME_BITS-1:0]   frame;
    logic [DATA_BITS-1:0]    shift_in;
    logic [COUNT_BITS-1:0]   words_to_go;
    logic [2:0]              cmd;
    logic                    cs_q;
    logic                    sk_q;
    logic                    di_q;
    result_t                 expected_pins[$];
    int                      errors;

    function new();
      state       = PH_IDLE;
      bits_left   = 0;
      frame       = '0;
      shift_in    = '0;
      words_to_go = '0;
      cmd         = ACT_TICK;
      cs_q        = 1'b0;
      sk_q        = 1'b0;
      di_q        = 1'b0;
      errors      = 0;
    endfunction

    function logic frame_bit();
      if (bits_left == 0) return 1'b0;
      return frame[bits_left-1];
    endfunction

    function void predict_tick(logic [2:0] act, logic [ADDR_BITS-1:0] addr,
                               logic [DATA_BITS-1:0] data,
                               logic [COUNT_BITS-1:0] cnt, logic sdi);
      result_t                exp;
      logic                   cs;
      logic                   sk;
      logic                   di;
      logic [1:0]             op;
      logic [ADDR_BITS-1:0]   a;
      cs  = cs_q;
      sk  = sk_q;
      di  = di_q;
      exp = '0;
      case (state)
        PH_IDLE: begin
          cs = 1'b0;
          sk = 1'b0;
          di = 1'b0;
          if (act >= ACT_READ && act <= ACT_WRAL) begin
            cmd = act;
            op  = OP_CTRL;
            a   = addr;
            case (act)
              ACT_READ:  op = OP_READ;
              ACT_WRITE: op = OP_WRITE;
              ACT_WEN:   a = '1;
              ACT_WDS:   a = '0;
              default:   a = {1'b0, {(ADDR_BITS-1){1'b1}}};
            endcase
            frame     = FRAME_BITS'({1'b1, op, a});
            bits_left = HEAD_BITS;
            if (act == ACT_WRITE || act == ACT_WRAL) begin
              frame     = {frame[HEAD_BITS-1:0], data};
              bits_left = FRAME_BITS;
            end
            cs    = 1'b1;
            state = PH_DUMMY;
          end
        end
        PH_DUMMY: begin
          if (!sk) begin
            sk = 1'b1;
          end else begin
            sk    = 1'b0;
            di    = frame_bit();
            state = PH_FRAME;
          end
        end
        PH_FRAME: begin
          if (!sk) begin
            sk = 1'b1;
          end else begin
            sk = 1'b0;
            if (bits_left > 0) bits_left = bits_left - 1;
            if (bits_left > 0) begin
              di = frame_bit();
            end else begin
              di = 1'b0;
              if (cmd == ACT_READ) begin
                state       = PH_READ;
                bits_left   = DATA_BITS;
                words_to_go = (cnt == '0) ? COUNT_BITS'(1) : cnt;
                shift_in    = '0;
              end else if (cmd == ACT_WRITE || cmd == ACT_WRAL) begin
                cs    = 1'b0;
                state = PH_GAP;
              end else begin
                cs    = 1'b0;
                state = PH_IDLE;
              end
            end
          end
        end
        PH_READ: begin
          if (!sk) begin
            sk = 1'b1;
          end else begin
            sk       = 1'b0;
            shift_in = {shift_in[DATA_BITS-2:0], sdi};
            if (bits_left > 0) bits_left = bits_left - 1;
            if (bits_left == 0) begin
              exp.valid = 1'b1;
              exp.word  = shift_in;
              if (words_to_go > 0) words_to_go = words_to_go - 1'b1;
              if (words_to_go == 0) begin
                exp.last = 1'b1;
                cs       = 1'b0;
                state    = PH_IDLE;
              end else begin
                bits_left = DATA_BITS;
              end
            end
          end
        end
        PH_GAP: begin
          cs    = 1'b1;
          sk    = 1'b0;
          di    = 1'b0;
          state = PH_POLL;
        end
        PH_POLL: begin
          if (sdi) begin
            cs    = 1'b0;
            state = PH_IDLE;
          end
        end
        default: begin
          cs    = 1'b0;
          sk    = 1'b0;
          di    = 1'b0;
          state = PH_IDLE;
        end
      endcase
      cs_q     = cs;
      sk_q     = sk;
      di_q     = di;
      exp.cs   = cs;
      exp.sk   = sk;
      exp.di   = di;
      exp.busy = (state != PH_IDLE);
      expected_pins.push_back(exp);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, exp, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_pins.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %p", $time, got);
        return;
      end
      exp = expected_pins.pop_front();
      compare_field("chip_select", exp.cs, got.cs);
      compare_field("serial_clock", exp.sk, got.sk);
      compare_field("serial_data_out", exp.di, got.di);
      compare_field("read_word", exp.word, got.word);
      compare_field("word_valid", exp.valid, got.valid);
      compare_field("last_word", exp.last, got.last);
      compare_field("busy_res", exp.busy, got.busy);
    endfunction

  endclass

endpackage

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the Microwire EEPROM master.
// Drives half-clock ticks carrying read, write, enable, disable and write-all
// commands, serial input data and device ready polling, with random gaps on
// the input side and random stalls on the result side. Every result word is
// checked against a tick-level predictor.
// ----------------------------------------------------------------------------
module tb_top;

  import mwem_pkg::*;
  import mwem_checker_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [2:0]            action;
  logic [ADDR_BITS-1:0]  address;
  logic [DATA_BITS-1:0]  write_data;
  logic [COUNT_BITS-1:0] word_count;
  logic                  serial_data_in;
  logic                  out_valid;
  logic                  out_ready;
  logic                  chip_select;
  logic                  serial_clock;
  logic                  serial_data_out;
  logic [DATA_BITS-1:0]  read_word;
  logic                  word_valid;
  logic                  last_word;
  logic                  busy_res;

  mwem_checker sb;
  int          ticks_sent;
  int          in_calm;
  int          out_calm;

  microwire_eeprom_master_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .address        (address),
    .write_data     (write_data),
    .word_count     (word_count),
    .serial_data_in (serial_data_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .chip_select    (chip_select),
    .serial_clock   (serial_clock),
    .serial_data_out(serial_data_out),
    .read_word      (read_word),
    .word_valid     (word_valid),
    .last_word      (last_word),
    .busy_res       (busy_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r == 0) begin
      calm = 150;
      return 0;
    end
    if (r < 110) return 0;
    if (r < 185) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_tick(logic [2:0] act, logic [ADDR_BITS-1:0] addr,
                           logic [DATA_BITS-1:0] data,
                           logic [COUNT_BITS-1:0] cnt, logic sdi);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    action         <= act;
    address        <= addr;
    write_data     <= data;
    word_count     <= cnt;
    serial_data_in <= sdi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_tick(act, addr, data, cnt, sdi);
    ticks_sent++;
  endtask

  // issue one command from idle, then tick with noise until it completes
  task automatic run_command(logic [2:0] act, logic [ADDR_BITS-1:0] addr,
                             logic [DATA_BITS-1:0] data,
                             logic [COUNT_BITS-1:0] cnt, int poll_low);
    int   polls;
    logic sdi;
    polls = 0;
    send_tick(act, addr, data, cnt, 1'($urandom));
    while (sb.state != PH_IDLE) begin
      if (sb.state == PH_POLL) begin
        sdi = (polls >= poll_low);
        polls++;
      end else begin
        sdi = 1'($urandom);
      end
      send_tick(3'($urandom), ADDR_BITS'($urandom), DATA_BITS'($urandom),
                COUNT_BITS'($urandom), sdi);
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
      repeat (pick_gap(out_calm)) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && out_valid && out_ready) begin
      got.cs    = chip_select;
      got.sk    = serial_clock;
      got.di    = serial_data_out;
      got.word  = read_word;
      got.valid = word_valid;
      got.last  = last_word;
      got.busy  = busy_res;
      sb.check_result(got);
    end
  end

  initial begin
    int               r;
    logic [2:0]       act;
    logic [COUNT_BITS-1:0] cnt;
    int               poll_low;
    rst            = 1'b1;
    in_valid       = 1'b0;
    action         = ACT_TICK;
    address        = '0;
    write_data     = '0;
    word_count     = '0;
    serial_data_in = 1'b0;
    ticks_sent     = 0;
    in_calm        = 0;
    out_calm       = 0;
    sb             = new();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    run_command(ACT_TICK, 8'h00, 16'h0000, 9'd0, 0);
    run_command(3'd6, 8'hFF, 16'hFFFF, 9'd1, 0);
    run_command(3'd7, 8'h3C, 16'h1234, 9'd2, 0);
    run_command(ACT_READ, 8'h00, 16'h0000, 9'd1, 0);
    run_command(ACT_READ, 8'hFF, 16'hFFFF, 9'd0, 0);
    run_command(ACT_READ, 8'h5A, 16'hA5A5, 9'd3, 0);
    run_command(ACT_READ, 8'hA5, 16'h0000, 9'd12, 0);
    run_command(ACT_WRITE, 8'h00, 16'h0000, 9'd1, 0);
    run_command(ACT_WRITE, 8'hFF, 16'hFFFF, 9'd1, 40);
    run_command(ACT_WRITE, 8'h80, 16'h8000, 9'd5, 2);
    run_command(ACT_WEN, 8'h00, 16'h0000, 9'd0, 0);
    run_command(ACT_WDS, 8'hFF, 16'hFFFF, 9'd0, 0);
    run_command(ACT_WRAL, 8'h12, 16'h8001, 9'd0, 3);
    run_command(ACT_WRAL, 8'h00, 16'hFFFF, 9'd0, 0);

    while (ticks_sent < 1800) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        act = $urandom_range(0, 1) ? ACT_TICK : 3'($urandom_range(6, 7));
        run_command(act, ADDR_BITS'($urandom), DATA_BITS'($urandom),
                    COUNT_BITS'($urandom), 0);
      end else begin
        act      = 3'($urandom_range(ACT_READ, ACT_WRAL));
        cnt      = (r < 13) ? COUNT_BITS'($urandom_range(5, 40))
                            : COUNT_BITS'($urandom_range(0, 4));
        poll_low = ($urandom_range(0, 99) < 5) ? $urandom_range(10, 60)
                                               : $urandom_range(0, 5);
        run_command(act, ADDR_BITS'($urandom), DATA_BITS'($urandom), cnt,
                    poll_low);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_pins.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[microwire_eeprom_master_top.f]
sv/mwem_pkg.sv
sv/mwem_fsm.sv
sv/microwire_eeprom_master_top.sv
verif/mwem_checker_pkg.sv
verif/tb_top.sv
